FILE: src/coherent_set_assoc_cache_controller_macros.svh
// Assertion macros used by the cache controller module.
`ifndef COHERENT_SET_ASSOC_CACHE_CONTROLLER_MACROS_SVH
`define COHERENT_SET_ASSOC_CACHE_CONTROLLER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CSC_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define CSC_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

FILE: src/csc_pkg.sv
package csc_pkg;

  localparam int unsigned DefNumSets   = 256;
  localparam int unsigned DefNumWays   = 8;
  localparam int unsigned DefOffBits   = 6;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_SNOOP = 2'd2;

  localparam logic [1:0] MODE_MSI    = 2'd0;
  localparam logic [1:0] MODE_DRAGON = 2'd1;

  localparam logic [1:0] SIG_RD  = 2'd1;
  localparam logic [1:0] SIG_RDX = 2'd2;
  localparam logic [1:0] SIG_UPD = 2'd3;

  localparam logic [2:0] REQ_NONE   = 3'd0;
  localparam logic [2:0] REQ_RD     = 3'd1;
  localparam logic [2:0] REQ_RDX    = 3'd2;
  localparam logic [2:0] REQ_UPD    = 3'd3;
  localparam logic [2:0] REQ_RD_UPD = 3'd4;

  localparam logic [3:0] ST_INV   = 4'd0;
  localparam logic [3:0] ST_CLEAN = 4'd1;
  localparam logic [3:0] ST_DIRTY = 4'd2;
  localparam logic [3:0] ST_MSI_C = 4'd3;
  localparam logic [3:0] ST_MSI_M = 4'd4;
  localparam logic [3:0] ST_DR_E  = 4'd5;
  localparam logic [3:0] ST_DR_SC = 4'd6;
  localparam logic [3:0] ST_DR_SM = 4'd7;
  localparam logic [3:0] ST_DR_M  = 4'd8;

  // Result item, packed hit in bit 0 upwards.
  typedef struct packed {
    logic       memory_transaction;
    logic       intervention;
    logic       invalidated;
    logic       flush;
    logic       write_back;
    logic [2:0] bus_request;
    logic       hit;
  } result_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;   // register the request and start the set read
    logic update;    // write the set back and latch the result
    logic clear;     // write one row of the clearing pass
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_last;
  } dp_sts_t;

endpackage

FILE: src/csc_datapath.sv
module csc_datapath #(
  parameter int unsigned NUM_SETS          = csc_pkg::DefNumSets,
  parameter int unsigned NUM_WAYS          = csc_pkg::DefNumWays,
  parameter int unsigned BLOCK_OFFSET_BITS = csc_pkg::DefOffBits
) (
  input  logic              clk,
  input  logic              rst_n,
  input  csc_pkg::dp_cmd_t  cmd,
  output csc_pkg::dp_sts_t  sts,
  input  logic [1:0]        protocol_mode,
  input  logic [1:0]        operation,
  input  logic [31:0]       address,
  input  logic [1:0]        bus_signal,
  input  logic              no_other_copies,
  output csc_pkg::result_t  result
);
  import csc_pkg::*;

  localparam int unsigned SetBits = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WayBits = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned RankBits = WayBits;
  localparam int unsigned UsedSetBits = $clog2(NUM_SETS);
  localparam int unsigned TagBits = 32 - BLOCK_OFFSET_BITS - UsedSetBits;
  localparam logic [RankBits:0] MaxRank = (RankBits + 1)'(NUM_WAYS - 1);

  typedef logic [NUM_WAYS-1:0][TagBits-1:0]  tag_row_t;
  typedef logic [NUM_WAYS-1:0][3:0]          st_row_t;
  typedef logic [NUM_WAYS-1:0][RankBits-1:0] rk_row_t;

  tag_row_t tag_mem [NUM_SETS];
  st_row_t  st_mem  [NUM_SETS];
  rk_row_t  rk_mem  [NUM_SETS];

  tag_row_t tag_rd_r;
  st_row_t  st_rd_r;
  rk_row_t  rk_rd_r;

  logic [SetBits-1:0] set_r, clr_set_r;
  logic [TagBits-1:0] tag_r;
  logic [1:0]         op_r, sig_r, mode_r;
  logic               alone_r;
  result_t            result_r;

  logic [31-BLOCK_OFFSET_BITS:0] block;
  logic [SetBits-1:0]            set_in;

  assign block = address[31:BLOCK_OFFSET_BITS];
  if (NUM_SETS > 1) begin : g_set
    assign set_in = block[SetBits-1:0];
  end else begin : g_noset
    assign set_in = '0;
  end

  // Read the set and capture the request.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tag_rd_r <= tag_mem[set_in];
      st_rd_r  <= st_mem[set_in];
      rk_rd_r  <= rk_mem[set_in];
      set_r    <= set_in;
      tag_r    <= TagBits'(block >> UsedSetBits);
      op_r     <= operation;
      sig_r    <= bus_signal;
      alone_r  <= no_other_copies;
      mode_r   <= protocol_mode;
    end
  end

  // Lookup, victim choice and protocol decision on the registered row.
  logic [NUM_WAYS-1:0] match, inval;
  logic                found, any_inv;
  logic [WayBits-1:0]  hit_way, inv_way, lru_way, way;
  logic [RankBits-1:0] best;
  logic [RankBits:0]   old_rank;
  logic [3:0]          s, s_nxt;
  st_row_t             st_nxt;
  rk_row_t             rk_nxt;
  tag_row_t            tag_nxt;
  result_t             res;
  logic                proc;

  always_comb begin
    found = 1'b0; hit_way = '0; any_inv = 1'b0; inv_way = '0;
    lru_way = '0; best = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      inval[w] = (st_rd_r[w] == ST_INV);
      match[w] = !inval[w] && (tag_rd_r[w] == tag_r);
    end
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        found = 1'b1; hit_way = WayBits'(w);
      end
      if (inval[w]) begin
        any_inv = 1'b1; inv_way = WayBits'(w);
      end
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (rk_rd_r[w] >= best) begin
        best = rk_rd_r[w]; lru_way = WayBits'(w);
      end
    end
  end

  always_comb begin
    proc = (op_r == OP_READ) || (op_r == OP_WRITE);
    way = found ? hit_way : (any_inv ? inv_way : lru_way);
    s = st_rd_r[way];
    s_nxt = s;
    res = '0;
    if (proc) begin
      res.hit = found;
      if (!found) begin
        res.memory_transaction = 1'b1;
        res.write_back = (s == ST_DIRTY) || (s == ST_MSI_M) || (s == ST_DR_M)
                      || (s == ST_DR_SM);
        if (mode_r == MODE_MSI) begin
          s_nxt = (op_r == OP_WRITE) ? ST_MSI_M : ST_MSI_C;
          res.bus_request = (op_r == OP_WRITE) ? REQ_RDX : REQ_RD;
        end else if (mode_r == MODE_DRAGON) begin
          if (op_r == OP_WRITE) begin
            s_nxt = alone_r ? ST_DR_M : ST_DR_SM;
            res.bus_request = alone_r ? REQ_RD : REQ_RD_UPD;
          end else begin
            s_nxt = alone_r ? ST_DR_E : ST_DR_SC;
            res.bus_request = REQ_RD;
          end
        end else begin
          s_nxt = (op_r == OP_WRITE) ? ST_DIRTY : ST_CLEAN;
        end
      end else if (op_r == OP_WRITE) begin
        if (mode_r == MODE_MSI) begin
          if (s != ST_MSI_M) res.bus_request = REQ_RDX;
          s_nxt = ST_MSI_M;
        end else if (mode_r == MODE_DRAGON) begin
          if (alone_r) begin
            if (s == ST_DR_SC || s == ST_DR_SM) res.bus_request = REQ_UPD;
            s_nxt = ST_DR_M;
          end else begin
            res.bus_request = REQ_UPD;
            s_nxt = ST_DR_SM;
          end
        end else begin
          s_nxt = ST_DIRTY;
        end
      end
    end else if (op_r == OP_SNOOP && found) begin
      res.hit = 1'b1;
      if (mode_r == MODE_MSI) begin
        if (sig_r == SIG_RD) begin
          if (s == ST_MSI_M) begin
            s_nxt = ST_MSI_C; res.flush = 1'b1;
          end
        end else if (sig_r == SIG_RDX) begin
          if (s == ST_MSI_M || s == ST_MSI_C) begin
            res.flush = (s == ST_MSI_M);
            s_nxt = ST_INV;
            res.invalidated = 1'b1;
          end
        end
      end else if (mode_r == MODE_DRAGON) begin
        if (sig_r == SIG_RD) begin
          if (s == ST_DR_E) begin
            s_nxt = ST_DR_SC; res.intervention = 1'b1;
          end else if (s == ST_DR_M) begin
            s_nxt = ST_DR_SM; res.flush = 1'b1; res.intervention = 1'b1;
          end else if (s == ST_DR_SM) begin
            res.flush = 1'b1;
          end
        end else if (sig_r == SIG_UPD) begin
          if (s == ST_DR_SM) s_nxt = ST_DR_SC;
        end
      end
      res.memory_transaction = res.flush;
    end

    // Row write-back values; ranks move only on a processor access.
    old_rank = (st_rd_r[way] != ST_INV) ? {1'b0, rk_rd_r[way]} : (RankBits + 1)'(NUM_WAYS);
    st_nxt = st_rd_r;
    rk_nxt = rk_rd_r;
    tag_nxt = tag_rd_r;
    st_nxt[way] = s_nxt;
    if (proc) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (WayBits'(w) != way && !inval[w] && {1'b0, rk_rd_r[w]} < old_rank
            && {1'b0, rk_rd_r[w]} < MaxRank) begin
          rk_nxt[w] = rk_rd_r[w] + 1'b1;
        end
      end
      rk_nxt[way] = '0;
      tag_nxt[way] = tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      st_mem[clr_set_r] <= '0;
      rk_mem[clr_set_r] <= '0;
    end else if (cmd.update) begin
      st_mem[set_r]  <= st_nxt;
      rk_mem[set_r]  <= rk_nxt;
      tag_mem[set_r] <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) result_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_set_r <= '0;
    end else if (cmd.clear) begin
      clr_set_r <= clr_set_r + 1'b1;
    end
  end

  assign sts.clear_last = (clr_set_r == SetBits'(NUM_SETS - 1));
  assign result = result_r;

endmodule

FILE: src/csc_controller.sv
module csc_controller (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output csc_pkg::dp_cmd_t cmd,
  input  csc_pkg::dp_sts_t sts
);
  import csc_pkg::*;
  `include "coherent_set_assoc_cache_controller_macros.svh"

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // A request is taken only when the result slot is free or emptying.
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.capture = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.update = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `CSC_ASSERT_NEXT(a_capture_then_update, clk, rst_n, cmd.capture, cmd.update, "capture not followed by update")
  `CSC_ASSERT_NEXT(a_update_gives_result, clk, rst_n, cmd.update, out_valid_r, "update lost its result")
  `CSC_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n, state_r == S_CLEAR, !in_tready, "request taken during clear")
  `CSC_ASSERT_IMP(a_update_slot_free, clk, rst_n, cmd.update, !out_valid_r || out_tready, "result overwritten")

endmodule

FILE: src/coherent_set_assoc_cache_controller.sv
// Set-associative cache tag and state controller with LRU replacement, running MSI,
// Dragon or plain write-back coherence as chosen by cfg_wdata (0 MSI, 1 Dragon, 2 or 3
// plain). Each request is a processor read, a processor write or a snooped bus signal;
// each gives exactly one result. A request has a read step, which reads the whole set
// (tags, line states and recency ranks) from the set memories, then an update step,
// which decides and writes the set back; no new request is accepted before that update.
// After reset a clearing pass writes the states and ranks of every set, during which no
// request is accepted; the protocol register may be written at any time then.
module coherent_set_assoc_cache_controller #(
  parameter int unsigned NUM_SETS          = csc_pkg::DefNumSets,
  parameter int unsigned NUM_WAYS          = csc_pkg::DefNumWays,
  parameter int unsigned BLOCK_OFFSET_BITS = csc_pkg::DefOffBits
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // operation[1:0], address[33:2], bus_signal[35:34],
                                 // no_other_copies[36], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata  // hit[0], bus_request[3:1], write_back[4], flush[5],
                                 // invalidated[6], intervention[7],
                                 // memory_transaction[8], zero fill
);
  import csc_pkg::*;

  logic [1:0] protocol_mode_r;
  dp_cmd_t    cmd;
  dp_sts_t    sts;
  result_t    result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      protocol_mode_r <= MODE_MSI;
    end else if (cfg_we) begin
      protocol_mode_r <= cfg_wdata;
    end
  end

  csc_controller u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .cmd, .sts
  );

  csc_datapath #(
    .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .BLOCK_OFFSET_BITS(BLOCK_OFFSET_BITS)
  ) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .protocol_mode   (protocol_mode_r),
    .operation       (in_tdata[1:0]),
    .address         (in_tdata[33:2]),
    .bus_signal      (in_tdata[35:34]),
    .no_other_copies (in_tdata[36]),
    .result
  );

  assign out_tdata = {7'd0, result};

endmodule
